// File: rtl/core/gcob_pkg.sv
// Shared types, constants and helpers for the glyph coverage over-blend core.
package gcob_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int CH_W           = 8;
    localparam int NUM_W          = 24;
    localparam int DEN_W          = 16;
    localparam int DIV_STEPS      = CH_W;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA  = 3'd5;

    localparam logic [CH_W-1:0]  CH_MAX         = 8'd255;
    localparam logic [DEN_W-1:0] ROUND_HALF     = 16'd127;
    localparam logic [DEN_W-1:0] RECIP_255      = 16'd32897;
    localparam int               RECIP_SHIFT    = 23;
    localparam logic [CH_W-1:0]  RST_TEXT       = 8'd255;
    localparam int               RST_WIDTH      = 640;
    localparam int               RST_HEIGHT     = 480;

    typedef struct packed {
        logic                       we;
        logic                       use_div;
        logic [2:0][NUM_W-1:0]      rem;
        logic [DEN_W-1:0]           den;
        logic [2:0][CH_W-1:0]       quot;
        logic [2:0][CH_W-1:0]       res;
        logic [CH_W-1:0]            alpha;
    } gcob_div_t;

    // floor(x / 255), exact for x below 65280
    function automatic logic [CH_W-1:0] div255(input logic [DEN_W:0] x);
        logic [2*DEN_W:0] prod;
        prod = {{DEN_W{1'b0}}, x} * {{(DEN_W+1){1'b0}}, RECIP_255};
        return prod[RECIP_SHIFT +: CH_W];
    endfunction

endpackage

// File: rtl/core/gcob_cfg.sv
// Configuration register file: text color, image size and alpha mode.
module gcob_cfg #(
    parameter int COORD_BITS = gcob_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gcob_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    output logic [2:0][gcob_pkg::CH_W-1:0]      text_color,
    output logic [COORD_BITS-1:0]               image_width,
    output logic [COORD_BITS-1:0]               image_height,
    output logic                                has_alpha
);
    import gcob_pkg::*;

    logic [2:0][CH_W-1:0]      text_reg;
    logic [COORD_BITS-1:0]     width_reg;
    logic [COORD_BITS-1:0]     height_reg;
    logic                      alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg   <= {3{RST_TEXT}};
            width_reg  <= COORD_BITS'(RST_WIDTH);
            height_reg <= COORD_BITS'(RST_HEIGHT);
            alpha_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEXT_RED:   text_reg[0] <= cfg_data[CH_W-1:0];
                REG_TEXT_GREEN: text_reg[1] <= cfg_data[CH_W-1:0];
                REG_TEXT_BLUE:  text_reg[2] <= cfg_data[CH_W-1:0];
                REG_IMG_WIDTH:  width_reg   <= cfg_data;
                REG_IMG_HEIGHT: height_reg  <= cfg_data;
                REG_HAS_ALPHA:  alpha_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign text_color   = text_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign has_alpha    = alpha_reg;

endmodule

// File: rtl/core/gcob_front.sv
// Front pipeline: clipping, blend products, numerators and constant divides.
module gcob_front #(
    parameter int COORD_BITS = gcob_pkg::COORD_BITS_DEF,
    parameter int IN_TDATA_W = 72
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [IN_TDATA_W-1:0]           in_data,
    input  logic [2:0][gcob_pkg::CH_W-1:0]  text_color,
    input  logic [COORD_BITS-1:0]           image_width,
    input  logic [COORD_BITS-1:0]           image_height,
    input  logic                            has_alpha,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gcob_pkg::gcob_div_t             out_data
);
    import gcob_pkg::*;

    localparam int X_LO = CH_W;
    localparam int Y_LO = X_LO + COORD_BITS + 1;
    localparam int P_LO = Y_LO + COORD_BITS + 1;

    logic [CH_W-1:0]          g_in;
    logic [COORD_BITS:0]      x_in;
    logic [COORD_BITS:0]      y_in;
    logic [2:0][CH_W-1:0]     p_in;
    logic [CH_W-1:0]          pa_in;
    logic                     in_image;
    logic                     en1;
    logic                     en2;
    logic                     en3;

    // stage 1
    logic                     v1_reg;
    logic                     we1_reg;
    logic                     ha1_reg;
    logic [CH_W-1:0]          g1_reg;
    logic [CH_W-1:0]          gi1_reg;
    logic [DEN_W-1:0]         gw1_reg;
    logic [DEN_W-1:0]         ga1_reg;
    logic [2:0][CH_W-1:0]     c1_reg;
    logic [2:0][CH_W-1:0]     p1_reg;
    logic [CH_W-1:0]          pa1_reg;

    // stage 2
    logic                     v2_reg;
    logic                     we2_reg;
    logic                     ha2_reg;
    logic [2:0][NUM_W-1:0]    num2_reg;
    logic [DEN_W-1:0]         den2_reg;
    logic [2:0][DEN_W-1:0]    mx2_reg;
    logic [2:0][CH_W-1:0]     p2_reg;
    logic [CH_W-1:0]          pa2_reg;
    logic [2:0][NUM_W-1:0]    num2_next;
    logic [2:0][DEN_W-1:0]    mx2_next;

    // stage 3
    logic                     v3_reg;
    gcob_div_t                d3_reg;
    gcob_div_t                d3_next;

    assign g_in  = in_data[CH_W-1:0];
    assign x_in  = in_data[X_LO +: COORD_BITS+1];
    assign y_in  = in_data[Y_LO +: COORD_BITS+1];
    assign p_in  = in_data[P_LO +: 3*CH_W];
    assign pa_in = in_data[P_LO+3*CH_W +: CH_W];

    assign in_image = !x_in[COORD_BITS] && !y_in[COORD_BITS]
                      && (x_in[COORD_BITS-1:0] < image_width)
                      && (y_in[COORD_BITS-1:0] < image_height);

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            we1_reg <= in_image && (g_in != '0);
            ha1_reg <= has_alpha;
            g1_reg  <= g_in;
            gi1_reg <= CH_MAX - g_in;
            gw1_reg <= DEN_W'(g_in) * DEN_W'(CH_MAX);
            ga1_reg <= DEN_W'(pa_in) * DEN_W'(CH_MAX - g_in);
            c1_reg  <= text_color;
            p1_reg  <= p_in;
            pa1_reg <= pa_in;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num2_next[i] = NUM_W'(c1_reg[i]) * NUM_W'(gw1_reg)
                           + NUM_W'(p1_reg[i]) * NUM_W'(ga1_reg);
            mx2_next[i]  = DEN_W'(p1_reg[i]) * DEN_W'(gi1_reg)
                           + DEN_W'(c1_reg[i]) * DEN_W'(g1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            we2_reg  <= we1_reg;
            ha2_reg  <= ha1_reg;
            num2_reg <= num2_next;
            den2_reg <= gw1_reg + ga1_reg;
            mx2_reg  <= mx2_next;
            p2_reg   <= p1_reg;
            pa2_reg  <= pa1_reg;
        end
    end

    always_comb
    begin
        d3_next.we      = we2_reg;
        d3_next.use_div = we2_reg && ha2_reg;
        d3_next.rem     = num2_reg;
        d3_next.den     = den2_reg;
        d3_next.quot    = '0;
        for (int i = 0; i < 3; i++)
        begin
            d3_next.res[i] = we2_reg ? div255({1'b0, mx2_reg[i]}) : p2_reg[i];
        end
        if (we2_reg && ha2_reg)
            d3_next.alpha = div255({1'b0, den2_reg} + {1'b0, ROUND_HALF});
        else
            d3_next.alpha = pa2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
            d3_reg <= d3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// File: rtl/core/gcob_div_stage.sv
// One restoring-division stage: resolves one quotient bit for all three channels.
module gcob_div_stage #(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gcob_pkg::gcob_div_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gcob_pkg::gcob_div_t  out_data
);
    import gcob_pkg::*;

    logic                 en;
    logic                 v_reg;
    gcob_div_t            d_reg;
    gcob_div_t            d_next;
    logic [NUM_W-1:0]     dsh;

    assign dsh = NUM_W'(in_data.den) << STEP;

    always_comb
    begin
        d_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            if (in_data.rem[i] >= dsh)
            begin
                d_next.rem[i]        = in_data.rem[i] - dsh;
                d_next.quot[i][STEP] = 1'b1;
            end
        end
    end

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: rtl/core/glyph_coverage_over_blend_core.sv
// Top level of the glyph coverage over-blend core.
//
// Usage: each input word on s_* carries one glyph coverage value, the signed
// destination column and row, and the current destination RGBA pixel. Each
// output word on m_* carries the blended RGBA pixel, with write_enable on
// m_tuser set when the pixel lies inside the image and coverage is nonzero.
// Pixels not written pass the destination values through unchanged.
// The cfg_* channel writes the text color, image size and alpha mode; it is
// always ready and should only be used while no words are in flight.
// The pipeline has three front stages (clip and products, numerators,
// divides by 255) and eight restoring-division stages, one quotient bit each.
// Throughput is one word per cycle; every stage holds its own valid bit.
// When the receiver stalls, words queue up in the stages and s_tready drops
// only once all eleven stages hold a word; no word is lost or repeated.
// Reset empties the pipeline and loads the default configuration: white text,
// 640 by 480 image, four-channel mode.
module glyph_coverage_over_blend_core #(
    parameter int COORD_BITS = gcob_pkg::COORD_BITS_DEF,
    localparam int IN_W       = 5 * gcob_pkg::CH_W + 2 * (COORD_BITS + 1),
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // coverage, pixel_x, pixel_y, dest_red, dest_green, dest_blue, dest_alpha
    input  logic [IN_TDATA_W-1:0]              s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [4*gcob_pkg::CH_W-1:0]        m_tdata,
    // write_enable
    output logic [0:0]                         m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gcob_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]              cfg_data
);
    import gcob_pkg::*;

    logic [2:0][CH_W-1:0]        text_color;
    logic [COORD_BITS-1:0]       image_width;
    logic [COORD_BITS-1:0]       image_height;
    logic                        has_alpha;

    logic [DIV_STEPS:0]          vld;
    logic [DIV_STEPS:0]          rdy;
    gcob_div_t                   dat [DIV_STEPS+1];
    gcob_div_t                   last;

    gcob_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_color   (text_color),
        .image_width  (image_width),
        .image_height (image_height),
        .has_alpha    (has_alpha)
    );

    gcob_front #(
        .COORD_BITS (COORD_BITS),
        .IN_TDATA_W (IN_TDATA_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_data      (s_tdata),
        .text_color   (text_color),
        .image_width  (image_width),
        .image_height (image_height),
        .has_alpha    (has_alpha),
        .out_valid    (vld[0]),
        .out_ready    (rdy[0]),
        .out_data     (dat[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        gcob_div_stage #(
            .STEP (DIV_STEPS - 1 - k)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_data   (dat[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_data  (dat[k+1])
        );
    end

    assign last            = dat[DIV_STEPS];
    assign rdy[DIV_STEPS]  = m_tready;
    assign m_tvalid        = vld[DIV_STEPS];
    assign m_tuser[0]      = last.we;
    assign m_tdata         = last.use_div
                             ? {last.alpha, last.quot[2], last.quot[1], last.quot[0]}
                             : {last.alpha, last.res[2], last.res[1], last.res[0]};

endmodule
